/* rtl/pfde_pkg.sv */
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared constants, codes and controller/datapath types of the page
// organized frame store draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int ROWS_PER_PAGE = 8;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
   localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;

   // widths
   localparam int BYTE_W  = 8;
   localparam int COORD_W = 8;
   localparam int SUM_W   = COORD_W + 1;
   localparam int ROW_SEL_W = $clog2(ROWS_PER_PAGE);
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int COL_W   = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int FUNC_W  = 3;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FILL   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

   // result status codes
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted item
      logic sweep_write; // write zero at the sweep address and advance
      logic iter_start;  // column and page iterators to the first byte
      logic mem_write;   // write the modified byte at the iterator address
      logic iter_next;   // advance to the next byte of the area
      logic capture;     // keep the read data for the result
      logic finish;      // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;        // item is rejected
      logic empty;      // rectangle with zero width or height
      logic is_clear;
      logic is_read;
      logic sweep_last;
      logic iter_last;
   } stat_type;

endpackage

/* rtl/pfde_if.sv */
// ----------------------------------------------------------------------------
// pfde channel interfaces
// Valid/ready channels for draw commands and their results.
// ----------------------------------------------------------------------------
interface pfde_req_if;
   logic                            valid;
   logic                            ready;
   logic [pfde_pkg::FUNC_W-1:0]     func;
   logic [pfde_pkg::COORD_W-1:0]    pos_x;
   logic [pfde_pkg::COORD_W-1:0]    pos_y;
   logic [pfde_pkg::COORD_W-1:0]    rect_width;
   logic [pfde_pkg::COORD_W-1:0]    rect_height;
   logic                            pixel_on;

   modport source (output valid, func, pos_x, pos_y, rect_width, rect_height, pixel_on,
                   input ready);
   modport sink   (input valid, func, pos_x, pos_y, rect_width, rect_height, pixel_on,
                   output ready);
endinterface

interface pfde_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [pfde_pkg::BYTE_W-1:0]   read_byte;

   modport source (output valid, status, read_byte, input ready);
   modport sink   (input valid, status, read_byte, output ready);
endinterface

/* rtl/pfde_ram.sv */
// ----------------------------------------------------------------------------
// pfde_ram
// Generic single port RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/pfde_datapath.sv */
// ----------------------------------------------------------------------------
// pfde_datapath
// Command registers, bounds checks, byte iterators, mask and modify logic,
// the frame store and the result register.
// ----------------------------------------------------------------------------
module pfde_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pfde_pkg::cmd_type             cmd,
   output pfde_pkg::stat_type            stat,
   input  logic [pfde_pkg::FUNC_W-1:0]   func,
   input  logic [pfde_pkg::COORD_W-1:0]  pos_x,
   input  logic [pfde_pkg::COORD_W-1:0]  pos_y,
   input  logic [pfde_pkg::COORD_W-1:0]  rect_width,
   input  logic [pfde_pkg::COORD_W-1:0]  rect_height,
   input  logic                          pixel_on,
   output logic                          status,
   output logic [pfde_pkg::BYTE_W-1:0]   read_byte
);

   localparam logic [pfde_pkg::SUM_W-1:0] WIDTH_LIM  = pfde_pkg::SUM_W'(pfde_pkg::SCREEN_WIDTH);
   localparam logic [pfde_pkg::SUM_W-1:0] HEIGHT_LIM = pfde_pkg::SUM_W'(pfde_pkg::SCREEN_HEIGHT);
   localparam logic [pfde_pkg::ADDR_W-1:0] SWEEP_END =
      pfde_pkg::ADDR_W'(pfde_pkg::STORE_DEPTH - 1);
   localparam logic [pfde_pkg::ROW_SEL_W-1:0] ROW_TOP =
      pfde_pkg::ROW_SEL_W'(pfde_pkg::ROWS_PER_PAGE - 1);

   // captured item
   logic [pfde_pkg::FUNC_W-1:0]  func_ff;
   logic [pfde_pkg::COORD_W-1:0] x_ff, y_ff, w_ff, h_ff;
   logic                         on_ff;

   // iterators and sweep counter
   logic [pfde_pkg::COL_W-1:0]   col_ff, col_in;
   logic [pfde_pkg::PAGE_W-1:0]  page_ff, page_in;
   logic [pfde_pkg::ADDR_W-1:0]  sweep_ff, sweep_in;

   // read capture and result
   logic [pfde_pkg::BYTE_W-1:0]  rd_ff;
   logic                         status_ff;
   logic [pfde_pkg::BYTE_W-1:0]  read_byte_ff;

   // decode
   logic                         is_rect, x_in, y_in, rect_fit, bad;
   logic [pfde_pkg::SUM_W-1:0]   x_end, y_end, x_last, y_last;
   logic [pfde_pkg::COL_W-1:0]   col_first, col_last;
   logic [pfde_pkg::PAGE_W-1:0]  page_first, page_last;
   logic [pfde_pkg::ROW_SEL_W-1:0] row_lo, row_hi;
   logic [pfde_pkg::BYTE_W-1:0]  mask, mod_byte, ram_wdata, ram_rdata;
   logic [pfde_pkg::ADDR_W-1:0]  pix_addr, ram_addr;
   logic                         ram_we;

   // capture accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func;
         x_ff    <= pos_x;
         y_ff    <= pos_y;
         w_ff    <= rect_width;
         h_ff    <= rect_height;
         on_ff   <= pixel_on;
      end
   end

   // bounds and edges, sums kept one bit wider so they never wrap
   always_comb begin
      is_rect  = (func_ff == pfde_pkg::FUNC_FILL) || (func_ff == pfde_pkg::FUNC_INVERT);
      x_end    = {1'b0, x_ff} + {1'b0, w_ff};
      y_end    = {1'b0, y_ff} + {1'b0, h_ff};
      x_in     = {1'b0, x_ff} < WIDTH_LIM;
      y_in     = {1'b0, y_ff} < HEIGHT_LIM;
      rect_fit = x_in && y_in && (x_end <= WIDTH_LIM) && (y_end <= HEIGHT_LIM);
      case (func_ff)
         pfde_pkg::FUNC_CLEAR:  bad = 1'b0;
         pfde_pkg::FUNC_SET:    bad = !(x_in && y_in);
         pfde_pkg::FUNC_READ:   bad = !(x_in && y_in);
         pfde_pkg::FUNC_FILL:   bad = !rect_fit;
         pfde_pkg::FUNC_INVERT: bad = !rect_fit;
         default:               bad = 1'b1;
      endcase
      x_last     = is_rect ? (x_end - 1'b1) : {1'b0, x_ff};
      y_last     = is_rect ? (y_end - 1'b1) : {1'b0, y_ff};
      col_first  = pfde_pkg::COL_W'(x_ff);
      col_last   = pfde_pkg::COL_W'(x_last);
      page_first = pfde_pkg::PAGE_W'(y_ff >> pfde_pkg::ROW_SEL_W);
      page_last  = pfde_pkg::PAGE_W'(y_last >> pfde_pkg::ROW_SEL_W);
   end

   // rows of the current page that the area covers
   always_comb begin
      row_lo = (page_ff == page_first) ? y_ff[pfde_pkg::ROW_SEL_W-1:0] : '0;
      row_hi = (page_ff == page_last) ? y_last[pfde_pkg::ROW_SEL_W-1:0] : ROW_TOP;
      mask   = ({pfde_pkg::BYTE_W{1'b1}} << row_lo) & ({pfde_pkg::BYTE_W{1'b1}} >> (ROW_TOP - row_hi));
      case (func_ff)
         pfde_pkg::FUNC_INVERT: mod_byte = ram_rdata ^ mask;
         default:               mod_byte = on_ff ? (ram_rdata | mask) : (ram_rdata & ~mask);
      endcase
   end

   // byte iterators: pages inner, columns outer
   always_comb begin
      col_in  = col_ff;
      page_in = page_ff;
      if (cmd.iter_start) begin
         col_in  = col_first;
         page_in = page_first;
      end else if (cmd.iter_next) begin
         if (page_ff == page_last) begin
            page_in = page_first;
            col_in  = col_ff + 1'b1;
         end else begin
            page_in = page_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      page_ff <= page_in;
   end

   // clearing sweep counter
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_write) begin
         sweep_in = (sweep_ff == SWEEP_END) ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   // store address and write port
   assign pix_addr  = pfde_pkg::ADDR_W'(int'(page_ff) * pfde_pkg::SCREEN_WIDTH + int'(col_ff));
   assign ram_addr  = cmd.sweep_write ? sweep_ff : pix_addr;
   assign ram_we    = cmd.sweep_write || cmd.mem_write;
   assign ram_wdata = cmd.sweep_write ? '0 : mod_byte;

   pfde_ram #(
      .WIDTH (pfde_pkg::BYTE_W),
      .DEPTH (pfde_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // read capture and result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= ram_rdata;
      end
      if (cmd.finish) begin
         status_ff    <= bad ? pfde_pkg::STATUS_REJECTED : pfde_pkg::STATUS_DONE;
         read_byte_ff <= ((func_ff == pfde_pkg::FUNC_READ) && !bad) ? rd_ff : '0;
      end
   end

   assign status    = status_ff;
   assign read_byte = read_byte_ff;

   // status to the controller
   always_comb begin
      stat.bad        = bad;
      stat.empty      = is_rect && ((w_ff == '0) || (h_ff == '0));
      stat.is_clear   = func_ff == pfde_pkg::FUNC_CLEAR;
      stat.is_read    = func_ff == pfde_pkg::FUNC_READ;
      stat.sweep_last = sweep_ff == SWEEP_END;
      stat.iter_last  = (page_ff == page_last) && (col_ff == col_last);
   end

endmodule

/* rtl/pfde_ctrl.sv */
// ----------------------------------------------------------------------------
// pfde_ctrl
// Sequencer of the draw engine: store clearing sweeps, read-modify-write
// walks over the touched bytes, byte reads and the result handshake.
// ----------------------------------------------------------------------------
module pfde_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pfde_pkg::cmd_type  cmd,
   input  pfde_pkg::stat_type stat
);

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_SWEEP   = 4'd3;
   localparam logic [3:0] S_RMW_RD  = 4'd4;
   localparam logic [3:0] S_RMW_WR  = 4'd5;
   localparam logic [3:0] S_RD_ADDR = 4'd6;
   localparam logic [3:0] S_RD_DATA = 4'd7;
   localparam logic [3:0] S_FINISH  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.iter_start = 1'b1;
            if (stat.bad || stat.empty) begin
               state_in = S_FINISH;
            end else if (stat.is_clear) begin
               state_in = S_SWEEP;
            end else if (stat.is_read) begin
               state_in = S_RD_ADDR;
            end else begin
               state_in = S_RMW_RD;
            end
         end
         S_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_RMW_RD: begin
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            cmd.mem_write = 1'b1;
            if (stat.iter_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.iter_next = 1'b1;
               state_in      = S_RMW_RD;
            end
         end
         S_RD_ADDR: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            cmd.capture = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            // wait while the previous result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a byte is written back only right after its read cycle
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW_WR) |-> ($past(state_ff) == S_RMW_RD))
      else $error("write-back without preceding read");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

   // the sweep never overlaps an item's byte walk
   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sweep_write && (cmd.mem_write || cmd.iter_next || cmd.capture)))
      else $error("sweep overlaps a byte access");

   // an accepted item is decoded in the following cycle
   a_decode_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DECODE))
      else $error("accepted item not decoded");

endmodule

/* rtl/page_framebuffer_draw_engine_unit.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit
// Monochrome page organized frame store with a draw engine: clear all,
// set/clear pixel, fill rectangle, invert rectangle and byte read.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  req_chan  in   valid/ready          func, pos_x, pos_y, rect_width,
//                                      rect_height, pixel_on
//  rsp_chan  out  valid/ready          status, read_byte
//
// One item at a time through a single port store of 1024 bytes.
// Set pixel, fill and invert read each touched byte and write it back
// through the one port; a byte read addresses the store, then captures the data.
// Clear all sweeps the whole store, one byte written per cycle.
// After reset a clearing pass over all 1024 bytes runs before the first item.
// A stalled result holds the next item's last step until taken; that
// next item is accepted while the result register still waits.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit (
   input  logic       clock,
   input  logic       reset,
   pfde_req_if.sink   req_chan,
   pfde_rsp_if.source rsp_chan
);

   pfde_pkg::cmd_type  cmd;
   pfde_pkg::stat_type stat;

   // sequencer
   pfde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // store and datapath
   pfde_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .func        (req_chan.func),
      .pos_x       (req_chan.pos_x),
      .pos_y       (req_chan.pos_y),
      .rect_width  (req_chan.rect_width),
      .rect_height (req_chan.rect_height),
      .pixel_on    (req_chan.pixel_on),
      .status      (rsp_chan.status),
      .read_byte   (rsp_chan.read_byte)
   );

endmodule

/* dv/page_framebuffer_draw_engine_unit_checker.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit_checker
// Watches the command and result channels of the draw engine. Every accepted
// command is applied to a private copy of the frame store to work out the
// expected status and read byte; results are compared in order.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit_checker (
   input  logic clock,
   input  logic reset,
   pfde_req_if  req_chan,
   pfde_rsp_if  rsp_chan,
   output int   mismatch_count,
   output int   outstanding
);
   import pfde_pkg::*;

   localparam int MAX_PRINTED = 200;

   typedef enum {PIX_CLEAR, PIX_SET, PIX_TOGGLE} pixel_op_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] read_byte;
   } draw_result_type;

   logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
   draw_result_type   awaited_results [$];
   int                result_index;

   // one pixel of the shadow store, caller keeps it on screen
   function automatic void touch_pixel(int x, int y, pixel_op_type op);
      int               idx;
      logic [BYTE_W-1:0] mask;
      idx  = x + (y / ROWS_PER_PAGE) * SCREEN_WIDTH;
      mask = BYTE_W'(1) << (y % ROWS_PER_PAGE);
      case (op)
         PIX_CLEAR: shadow_store[idx] = shadow_store[idx] & ~mask;
         PIX_SET:   shadow_store[idx] = shadow_store[idx] | mask;
         default:   shadow_store[idx] = shadow_store[idx] ^ mask;
      endcase
   endfunction

   // rectangle walk, returns 0 when any edge leaves the screen
   function automatic logic paint_rect(int x, int y, int w, int h, pixel_op_type op);
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT ||
          x + w > SCREEN_WIDTH || y + h > SCREEN_HEIGHT)
         return 1'b0;
      for (int cx = x; cx < x + w; cx++)
         for (int cy = y; cy < y + h; cy++)
            touch_pixel(cx, cy, op);
      return 1'b1;
   endfunction

   // apply one draw command to the shadow store and give its result
   function automatic draw_result_type apply_draw_command(
      logic [FUNC_W-1:0] func, int x, int y, int w, int h, logic on);
      draw_result_type res;
      logic            on_screen;
      res       = '{status: STATUS_DONE, read_byte: '0};
      on_screen = (x < SCREEN_WIDTH) && (y < SCREEN_HEIGHT);
      case (func)
         FUNC_CLEAR: begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
         end
         FUNC_SET: begin
            if (on_screen) touch_pixel(x, y, on ? PIX_SET : PIX_CLEAR);
            else res.status = STATUS_REJECTED;
         end
         FUNC_FILL: begin
            if (!paint_rect(x, y, w, h, on ? PIX_SET : PIX_CLEAR))
               res.status = STATUS_REJECTED;
         end
         FUNC_INVERT: begin
            if (!paint_rect(x, y, w, h, PIX_TOGGLE)) res.status = STATUS_REJECTED;
         end
         FUNC_READ: begin
            if (on_screen)
               res.read_byte = shadow_store[x + (y / ROWS_PER_PAGE) * SCREEN_WIDTH];
            else
               res.status = STATUS_REJECTED;
         end
         default: res.status = STATUS_REJECTED;
      endcase
      return res;
   endfunction

   // one line per mismatch, printing capped to keep the log short
   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                  $realtime, result_index, what, got, want);
   endtask

   // result side first, then the new command of the same edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = '0;
         awaited_results.delete();
         mismatch_count = 0;
         result_index   = 0;
         outstanding   <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result, status", rsp_chan.status, 0);
            end else begin
               draw_result_type want;
               want = awaited_results.pop_front();
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (rsp_chan.read_byte !== want.read_byte)
                  report_mismatch("read_byte", rsp_chan.read_byte, want.read_byte);
            end
            result_index++;
         end
         if (req_chan.valid && req_chan.ready)
            awaited_results.push_back(apply_draw_command(
               req_chan.func, req_chan.pos_x, req_chan.pos_y,
               req_chan.rect_width, req_chan.rect_height, req_chan.pixel_on));
         outstanding <= awaited_results.size();
      end
   end

endmodule

/* dv/page_framebuffer_draw_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit_tb
// Drives draw commands into the frame store engine: a directed pass over the
// screen edges, rejections and empty rectangles, then random drawing with
// mostly small rectangles, under changing sender and receiver idle rates.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit_tb;
   import pfde_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int TAIL_CYCLES  = 64;
   localparam int PHASE_ITEMS  = 400;
   localparam int SMALL_SPAN   = 12;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LOW  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HIGH = 3'd7;
   localparam logic [COORD_W-1:0] MAX_X = COORD_W'(SCREEN_WIDTH - 1);
   localparam logic [COORD_W-1:0] MAX_Y = COORD_W'(SCREEN_HEIGHT - 1);

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   rsp_idle_pct;
   int   cycle_count = 0;
   int   mismatch_count;
   int   outstanding;

   pfde_req_if req_chan ();
   pfde_rsp_if rsp_chan ();

   page_framebuffer_draw_engine_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   page_framebuffer_draw_engine_unit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result receiver with random stalls
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // random gap, then hold the item until it is taken
   task automatic issue_command(logic [FUNC_W-1:0] func, logic [COORD_W-1:0] x,
                                logic [COORD_W-1:0] y, logic [COORD_W-1:0] w,
                                logic [COORD_W-1:0] h, logic on);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= func;
      req_chan.pos_x       <= x;
      req_chan.pos_y       <= y;
      req_chan.rect_width  <= w;
      req_chan.rect_height <= h;
      req_chan.pixel_on    <= on;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // random drawing: clear, set, read and rectangles, these mostly small, a few near full screen, some noise
   task automatic random_command();
      int                pick;
      int                kind;
      int                room_x;
      int                room_y;
      logic [FUNC_W-1:0] func;
      logic [COORD_W-1:0] x, y, w, h;
      logic              on;
      pick = $urandom_range(999);
      on   = 1'($urandom_range(1));
      x    = COORD_W'($urandom_range(SCREEN_WIDTH - 1));
      y    = COORD_W'($urandom_range(SCREEN_HEIGHT - 1));
      w    = COORD_W'($urandom);
      h    = COORD_W'($urandom);
      if (pick < 50) begin
         // every field fully random, unknown codes included
         func = FUNC_W'($urandom);
         x    = COORD_W'($urandom);
         y    = COORD_W'($urandom);
      end else if (pick < 65) begin
         func = FUNC_CLEAR;
      end else if (pick < 300) begin
         func = FUNC_SET;
         if ($urandom_range(19) == 0) begin
            x = COORD_W'($urandom_range(255, SCREEN_WIDTH / 2));
            y = COORD_W'($urandom_range(255, SCREEN_HEIGHT / 2));
         end
      end else if (pick < 560) begin
         func = FUNC_READ;
         if ($urandom_range(19) == 0) y = COORD_W'($urandom_range(255, SCREEN_HEIGHT));
      end else begin
         func   = $urandom_range(1) ? FUNC_FILL : FUNC_INVERT;
         kind   = $urandom_range(99);
         room_x = SCREEN_WIDTH - x;
         room_y = SCREEN_HEIGHT - y;
         if (kind < 4) begin
            // near full screen
            x = COORD_W'($urandom_range(3));
            y = COORD_W'($urandom_range(3));
            w = COORD_W'(SCREEN_WIDTH - x - $urandom_range(3));
            h = COORD_W'(SCREEN_HEIGHT - y - $urandom_range(3));
         end else if (kind < 14) begin
            // one edge just or far past the screen
            if ($urandom_range(1)) begin
               w = COORD_W'($urandom_range(255, room_x + 1));
               h = COORD_W'($urandom_range(room_y < SMALL_SPAN ? room_y : SMALL_SPAN));
            end else begin
               w = COORD_W'($urandom_range(room_x < SMALL_SPAN ? room_x : SMALL_SPAN));
               h = COORD_W'($urandom_range(255, room_y + 1));
            end
         end else begin
            w = COORD_W'($urandom_range(room_x < SMALL_SPAN ? room_x : SMALL_SPAN));
            h = COORD_W'($urandom_range(room_y < SMALL_SPAN ? room_y : SMALL_SPAN));
         end
      end
      issue_command(func, x, y, w, h, on);
   endtask

   // stimulus and verdict
   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.func        <= FUNC_CLEAR;
      req_chan.pos_x       <= '0;
      req_chan.pos_y       <= '0;
      req_chan.rect_width  <= '0;
      req_chan.rect_height <= '0;
      req_chan.pixel_on    <= 1'b0;
      send_idle_pct = 8;
      rsp_idle_pct  = 78;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, rejections, wrap of edge sums, empty rectangles
      issue_command(FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
      issue_command(FUNC_SET,    MAX_X,  MAX_Y,  8'd0,   8'd0,   1'b1);
      issue_command(FUNC_READ,   MAX_X,  8'd56,  8'd0,   8'd0,   1'b0);
      issue_command(FUNC_SET,    8'd0,   8'd0,   8'd255, 8'd255, 1'b1);
      issue_command(FUNC_READ,   8'd0,   8'd7,   8'd0,   8'd0,   1'b0);
      issue_command(FUNC_SET,    8'd128, 8'd0,   8'd0,   8'd0,   1'b1);
      issue_command(FUNC_SET,    8'd0,   8'd64,  8'd0,   8'd0,   1'b1);
      issue_command(FUNC_SET,    8'd255, 8'd255, 8'd0,   8'd0,   1'b1);
      issue_command(FUNC_READ,   8'd128, 8'd0,   8'd0,   8'd0,   1'b0);
      issue_command(FUNC_READ,   8'd0,   8'd255, 8'd0,   8'd0,   1'b0);
      issue_command(FUNC_FILL,   8'd0,   8'd0,   8'd128, 8'd64,  1'b1);
      issue_command(FUNC_READ,   8'd64,  8'd32,  8'd0,   8'd0,   1'b0);
      issue_command(FUNC_INVERT, 8'd3,   8'd5,   8'd10,  8'd7,   1'b0);
      issue_command(FUNC_READ,   8'd5,   8'd0,   8'd0,   8'd0,   1'b0);
      issue_command(FUNC_FILL,   8'd1,   8'd0,   8'd128, 8'd1,   1'b1);
      issue_command(FUNC_FILL,   8'd0,   8'd1,   8'd1,   8'd64,  1'b1);
      issue_command(FUNC_INVERT, 8'd100, 8'd0,   8'd200, 8'd1,   1'b0);
      issue_command(FUNC_FILL,   8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
      issue_command(FUNC_FILL,   8'd10,  8'd10,  8'd0,   8'd5,   1'b0);
      issue_command(FUNC_INVERT, 8'd10,  8'd10,  8'd5,   8'd0,   1'b1);
      issue_command(FUNC_INVERT, MAX_X,  MAX_Y,  8'd1,   8'd1,   1'b1);
      issue_command(FUNC_SET,    8'd3,   8'd5,   8'd0,   8'd0,   1'b0);
      issue_command(FUNC_READ,   8'd3,   8'd0,   8'd0,   8'd0,   1'b1);
      issue_command(FUNC_UNKNOWN_LOW,  8'd0, 8'd0, 8'd1, 8'd1,   1'b1);
      issue_command(FUNC_UNKNOWN_HIGH, 8'd5, 8'd5, 8'd1, 8'd1,   1'b0);
      issue_command(FUNC_CLEAR,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      issue_command(FUNC_READ,   MAX_X,  MAX_Y,  8'd0,   8'd0,   1'b0);

      // random: receiver stalls, then sender gaps, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 1) ? 78 : (phase == 0) ? 8 : 0;
         rsp_idle_pct  = (phase == 0) ? 78 : (phase == 1) ? 8 : 0;
         repeat (PHASE_ITEMS) random_command();
      end
      req_chan.valid <= 1'b0;

      // drain and watch for stray results
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* page_framebuffer_draw_engine_unit.f */
rtl/pfde_pkg.sv
rtl/pfde_if.sv
rtl/pfde_ram.sv
rtl/pfde_datapath.sv
rtl/pfde_ctrl.sv
rtl/page_framebuffer_draw_engine_unit.sv
dv/page_framebuffer_draw_engine_unit_checker.sv
dv/page_framebuffer_draw_engine_unit_tb.sv
